// File: hw/rtl/gdn_pkg.sv
// gdn_pkg: shared beat types and function codes for the day number converter
// no dependencies; imported by every module of the block
`default_nettype none

package gdn_pkg;

  // function select codes
  localparam logic FUNC_DATE_TO_DN = 1'b0;
  localparam logic FUNC_DN_TO_DATE = 1'b1;

  // input beat
  typedef struct packed {
    logic        func;
    logic [13:0] in_year;
    logic [3:0]  in_month;
    logic [4:0]  in_day;
    logic [22:0] in_day_number;
  } in_beat_t;

  // result beat
  typedef struct packed {
    logic [22:0] day_number;
    logic [13:0] year;
    logic [3:0]  month;
    logic [4:0]  day;
    logic [8:0]  day_in_year;
    logic        range_error;
  } out_beat_t;

  // date resolved by the front pipe, handed on to the ordinal pipe
  typedef struct packed {
    logic        func;
    logic        range_error;
    logic [22:0] day_number;
    logic [13:0] year;
    logic [3:0]  month;
    logic [4:0]  day;
  } mid_t;

endpackage

`default_nettype wire

// File: hw/rtl/gdn_richards.sv
// gdn_richards: eleven-stage pipe that turns a day number into year, month and day
// depends on gdn_pkg; date-to-day-number beats pass through with their fields unchanged
`default_nettype none

module gdn_richards (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             in_valid_i,
  output logic                  in_stall_o,
  input  wire gdn_pkg::in_beat_t in_beat_i,
  input  wire logic             in_err_i,
  output logic                  out_valid_o,
  input  wire logic             out_stall_i,
  output gdn_pkg::mid_t          out_mid_o
);

  import gdn_pkg::*;

  localparam int NS          = 11;
  // reciprocal multipliers are split into two narrow partial products
  localparam int RECIP_SPLIT = 13;
  localparam int SPLIT_RADIX = 2 ** RECIP_SPLIT;
  // (4*jn + 274277) / 146097
  localparam int A_OFS       = 274277;
  localparam int A_RECIP     = 60207212;
  localparam int A_RECIP_HI  = A_RECIP / SPLIT_RADIX;
  localparam int A_RECIP_LO  = A_RECIP % SPLIT_RADIX;
  localparam int A_SHIFT     = 43;
  // f = jn + 1401 + b - 38
  localparam int F_OFS       = 1401 - 38;
  // e / 1461 and e % 1461
  localparam int YEAR_CYCLE  = 1461;
  localparam int B_RECIP     = 47035919;
  localparam int B_RECIP_HI  = B_RECIP / SPLIT_RADIX;
  localparam int B_RECIP_LO  = B_RECIP % SPLIT_RADIX;
  localparam int B_SHIFT     = 36;
  // h / 153
  localparam int MONTH_SPAN  = 153;
  localparam int H_RECIP     = 3427;
  localparam int H_SHIFT     = 19;
  // rh / 5
  localparam int DAY_RECIP   = 205;
  localparam int DAY_SHIFT   = 10;
  localparam int EPOCH_YEAR  = 4716;
  localparam int MONTHS      = 12;

  typedef struct packed {
    logic        func;
    logic        err;
    logic [13:0] yr;
    logic [3:0]  mo;
    logic [4:0]  dy;
    logic [22:0] jn;
    logic [25:0] x;
    logic [38:0] pa_hi;
    logic [38:0] pa_lo;
    logic [7:0]  a;
    logic [22:0] f;
    logic [37:0] pb_hi;
    logic [37:0] pb_lo;
    logic [14:0] q;
    logic [24:0] qm;
    logic [10:0] h;
    logic [3:0]  qh;
    logic [7:0]  rh;
    logic [3:0]  mon;
  } fr_t;

  logic [NS-1:0] vld_q;
  logic [NS:0]   rdy;
  fr_t           st_q [NS];
  fr_t           st_d [NS];

  logic [51:0] sum_a;
  logic [9:0]  b_w;
  logic [24:0] e_w;
  logic [50:0] sum_b;
  logic [25:0] qm_w;
  logic [24:0] r_w;
  logic [8:0]  g_w;
  logic [22:0] qh_w;
  logic [10:0] rh_w;
  logic [3:0]  mm_w;
  logic [14:0] dom_w;
  logic [14:0] y_w;

  // a stage moves when it is empty or its successor moves
  always_comb begin
    rdy[NS] = !out_stall_i;
    for (int k = NS - 1; k >= 0; k--) begin
      rdy[k] = !vld_q[k] || rdy[k+1];
    end
  end

  assign in_stall_o  = !rdy[0];
  assign out_valid_o = vld_q[NS-1];

  // per-stage arithmetic
  always_comb begin
    sum_a = (52'(st_q[1].pa_hi) << RECIP_SPLIT) + 52'(st_q[1].pa_lo);
    b_w   = (10'(st_q[2].a) + {1'b0, st_q[2].a, 1'b0}) >> 2;
    e_w   = {st_q[3].f, 2'b11};
    sum_b = (51'(st_q[4].pb_hi) << RECIP_SPLIT) + 51'(st_q[4].pb_lo);
    qm_w  = 26'(st_q[5].q) * 26'(YEAR_CYCLE);
    r_w   = {st_q[6].f, 2'b11} - st_q[6].qm;
    g_w   = r_w[10:2];
    qh_w  = 23'(st_q[7].h) * 23'(H_RECIP);
    rh_w  = st_q[8].h - 11'(12'(st_q[8].qh) * 12'(MONTH_SPAN));
    // (qh + 2) mod 12, qh + 2 never reaches 24
    if (st_q[8].qh + 4'd2 >= 4'(MONTHS)) begin
      mm_w = st_q[8].qh + 4'd2 - 4'(MONTHS);
    end else begin
      mm_w = st_q[8].qh + 4'd2;
    end
    dom_w = 15'(st_q[9].rh) * 15'(DAY_RECIP);
    y_w   = st_q[9].q - 15'(EPOCH_YEAR) + 15'(st_q[9].mon <= 4'd2);

    // stage 0: capture and form 4*jn + offset
    st_d[0]       = '0;
    st_d[0].func  = in_beat_i.func;
    st_d[0].err   = in_err_i;
    st_d[0].yr    = in_beat_i.in_year;
    st_d[0].mo    = in_beat_i.in_month;
    st_d[0].dy    = in_beat_i.in_day;
    st_d[0].jn    = in_beat_i.in_day_number;
    st_d[0].x     = 26'({in_beat_i.in_day_number, 2'b00}) + 26'(A_OFS);

    // stage 1: partial products of the 400-year cycle quotient
    st_d[1]       = st_q[0];
    st_d[1].pa_hi = 39'(st_q[0].x) * 39'(A_RECIP_HI);
    st_d[1].pa_lo = 39'(st_q[0].x) * 39'(A_RECIP_LO);

    // stage 2: recombine and take the quotient
    st_d[2]       = st_q[1];
    st_d[2].a     = sum_a[A_SHIFT +: 8];

    // stage 3: century correction and shifted day count
    st_d[3]       = st_q[2];
    st_d[3].f     = st_q[2].jn + 23'(F_OFS) + 23'(b_w);

    // stage 4: partial products of the four-year cycle quotient
    st_d[4]       = st_q[3];
    st_d[4].pb_hi = 38'(e_w) * 38'(B_RECIP_HI);
    st_d[4].pb_lo = 38'(e_w) * 38'(B_RECIP_LO);

    // stage 5: recombine and take the quotient
    st_d[5]       = st_q[4];
    st_d[5].q     = sum_b[B_SHIFT +: 15];

    // stage 6: quotient back-multiplied for the remainder
    st_d[6]       = st_q[5];
    st_d[6].qm    = 25'(qm_w);

    // stage 7: day within the four-year cycle, scaled for the month split
    st_d[7]       = st_q[6];
    st_d[7].h     = 11'({g_w, 2'b00}) + 11'(g_w) + 11'd2;

    // stage 8: month quotient from h
    st_d[8]       = st_q[7];
    st_d[8].qh    = qh_w[H_SHIFT +: 4];

    // stage 9: remainder within the month and the month number
    st_d[9]       = st_q[8];
    st_d[9].rh    = rh_w[7:0];
    st_d[9].mon   = mm_w + 4'd1;

    // stage 10: day of month and year, merged into the date fields
    st_d[10]      = st_q[9];
    if (st_q[9].func == FUNC_DN_TO_DATE) begin
      st_d[10].yr = y_w[13:0];
      st_d[10].mo = st_q[9].mon;
      st_d[10].dy = dom_w[DAY_SHIFT +: 5] + 5'd1;
    end
  end

  // stage valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      if (rdy[0]) begin
        vld_q[0] <= in_valid_i;
      end
      for (int k = 1; k < NS; k++) begin
        if (rdy[k]) begin
          vld_q[k] <= vld_q[k-1];
        end
      end
    end
  end

  // stage payload
  always_ff @(posedge clk_i) begin
    for (int k = 0; k < NS; k++) begin
      if (rdy[k]) begin
        st_q[k] <= st_d[k];
      end
    end
  end

  // hand the resolved date on
  always_comb begin
    out_mid_o.func        = st_q[NS-1].func;
    out_mid_o.range_error = st_q[NS-1].err;
    out_mid_o.day_number  = st_q[NS-1].jn;
    out_mid_o.year        = st_q[NS-1].yr;
    out_mid_o.month       = st_q[NS-1].mo;
    out_mid_o.day         = st_q[NS-1].dy;
  end

endmodule

`default_nettype wire

// File: hw/rtl/gdn_ordinal.sv
// gdn_ordinal: three-stage pipe for leap year, day of year and day number of a date
// depends on gdn_pkg; its last stage is the block's output register
`default_nettype none

module gdn_ordinal (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          in_valid_i,
  output logic               in_stall_o,
  input  wire gdn_pkg::mid_t in_mid_i,
  output logic               out_valid_o,
  input  wire logic          out_stall_i,
  output gdn_pkg::out_beat_t out_beat_o
);

  import gdn_pkg::*;

  localparam int NS            = 3;
  localparam int DN_BASE       = 1721425;
  localparam int DAYS_PER_YEAR = 365;
  localparam int CENTURY       = 100;
  // year / 100 for years below 10000
  localparam int CENT_RECIP    = 5243;
  localparam int CENT_SHIFT    = 19;

  typedef struct packed {
    mid_t        mid;
    logic [13:0] p;
    logic [7:0]  qy;
    logic [22:0] p365;
    logic [22:0] acc;
    logic [7:0]  qp;
    logic [8:0]  doy;
  } bk_t;

  logic [NS-1:0] vld_q;
  logic [NS:0]   rdy;
  bk_t           st0_q, st0_d;
  bk_t           st1_q, st1_d;
  out_beat_t     out_q, out_d;

  logic [26:0]   qy_w;
  logic [13:0]   p_w;
  logic [13:0]   ry_w;
  logic          ry_zero;
  logic          leap_w;
  logic [22:0]   dn_w;

  // days before the first of month m
  function automatic logic [8:0] month_start(input logic [3:0] m, input logic leap);
    logic [8:0] r;
    unique case (m)
      4'd1:    r = 9'd0;
      4'd2:    r = 9'd31;
      4'd3:    r = 9'd59;
      4'd4:    r = 9'd90;
      4'd5:    r = 9'd120;
      4'd6:    r = 9'd151;
      4'd7:    r = 9'd181;
      4'd8:    r = 9'd212;
      4'd9:    r = 9'd243;
      4'd10:   r = 9'd273;
      4'd11:   r = 9'd304;
      4'd12:   r = 9'd334;
      default: r = 9'd0;
    endcase
    if (leap && m >= 4'd3 && m <= 4'd12) begin
      r = r + 9'd1;
    end
    return r;
  endfunction

  // a stage moves when it is empty or its successor moves
  always_comb begin
    rdy[NS] = !out_stall_i;
    for (int k = NS - 1; k >= 0; k--) begin
      rdy[k] = !vld_q[k] || rdy[k+1];
    end
  end

  assign in_stall_o  = !rdy[0];
  assign out_valid_o = vld_q[NS-1];
  assign out_beat_o  = out_q;

  // stage 0: century quotient and whole years in days
  always_comb begin
    qy_w       = 27'(in_mid_i.year) * 27'(CENT_RECIP);
    p_w        = in_mid_i.year - 14'd1;
    st0_d      = '0;
    st0_d.mid  = in_mid_i;
    st0_d.p    = p_w;
    st0_d.qy   = qy_w[CENT_SHIFT +: 8];
    st0_d.p365 = 23'(p_w) * 23'(DAYS_PER_YEAR);
  end

  // stage 1: leap rule, day of year and the day count of prior years
  always_comb begin
    ry_w      = st0_q.mid.year - 14'(15'(st0_q.qy) * 15'(CENTURY));
    ry_zero   = (ry_w == 14'd0);
    leap_w    = (st0_q.mid.year[1:0] == 2'd0 && !ry_zero)
             || (ry_zero && st0_q.qy[1:0] == 2'd0);
    st1_d     = st0_q;
    st1_d.qp  = st0_q.qy - 8'(ry_zero);
    st1_d.doy = month_start(st0_q.mid.month, leap_w) + 9'(st0_q.mid.day);
    st1_d.acc = st0_q.p365 + 23'(st0_q.p >> 2) + 23'(DN_BASE);
  end

  // stage 2: day number and the result beat, cleared on a range error
  always_comb begin
    dn_w  = st1_q.acc - 23'(st1_q.qp) + 23'(st1_q.qp >> 2) + 23'(st1_q.doy);
    out_d = '0;
    if (!st1_q.mid.range_error) begin
      out_d.day_number  = (st1_q.mid.func == FUNC_DN_TO_DATE) ? st1_q.mid.day_number : dn_w;
      out_d.year        = st1_q.mid.year;
      out_d.month       = st1_q.mid.month;
      out_d.day         = st1_q.mid.day;
      out_d.day_in_year = st1_q.doy;
    end else begin
      out_d.range_error = 1'b1;
    end
  end

  // stage valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      if (rdy[0]) begin
        vld_q[0] <= in_valid_i;
      end
      for (int k = 1; k < NS; k++) begin
        if (rdy[k]) begin
          vld_q[k] <= vld_q[k-1];
        end
      end
    end
  end

  // stage payload
  always_ff @(posedge clk_i) begin
    if (rdy[0]) begin
      st0_q <= st0_d;
    end
    if (rdy[1]) begin
      st1_q <= st1_d;
    end
    if (rdy[2]) begin
      out_q <= out_d;
    end
  end

endmodule

`default_nettype wire

// File: hw/rtl/gregorian_day_number_converter.sv
// gregorian_day_number_converter: top level of the date / day number converter
// depends on gdn_pkg, gdn_richards and gdn_ordinal
`default_nettype none

// Converts between proleptic Gregorian dates and Julian day numbers. With func low
// a beat carries year, month and day and the result gives the day of year and the
// day number; with func high it carries a day number (1721426 to 5373484) and the
// result gives year, month, day and day of year. Out of range inputs return a beat
// with range_error set and every other field zero; a day past the end of its month
// is accepted and rolls into the next month's count. The block is a 14-stage
// pipeline: eleven stages resolve the date from a day number, three more work out
// the leap year, day of year and day number. A new beat is taken every cycle while
// the output is not stalled. A stage advances whenever it is empty or the stage
// after it advances, so a stall at the output holds the whole queue without losing
// a beat and bubbles are squeezed out; in_stall_o follows out_stall_i through that
// ready chain.

module gregorian_day_number_converter (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  output logic                   in_stall_o,
  input  wire gdn_pkg::in_beat_t  in_beat_i,
  output logic                   out_valid_o,
  input  wire logic              out_stall_i,
  output gdn_pkg::out_beat_t      out_beat_o
);

  import gdn_pkg::*;

  localparam logic [22:0] DN_MIN    = 23'd1721426;
  localparam logic [22:0] DN_MAX    = 23'd5373484;
  localparam logic [13:0] YEAR_MAX  = 14'd9999;
  localparam logic [3:0]  MONTH_MAX = 4'd12;

  logic range_err;
  logic mid_valid;
  logic mid_stall;
  mid_t mid_beat;

  // range check on the fields that the selected function uses
  always_comb begin
    if (in_beat_i.func == FUNC_DN_TO_DATE) begin
      range_err = (in_beat_i.in_day_number < DN_MIN) || (in_beat_i.in_day_number > DN_MAX);
    end else begin
      range_err = (in_beat_i.in_year == 14'd0) || (in_beat_i.in_year > YEAR_MAX)
               || (in_beat_i.in_month == 4'd0) || (in_beat_i.in_month > MONTH_MAX)
               || (in_beat_i.in_day == 5'd0);
    end
  end

  // day number to date
  gdn_richards u_richards (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_beat_i   (in_beat_i),
    .in_err_i    (range_err),
    .out_valid_o (mid_valid),
    .out_stall_i (mid_stall),
    .out_mid_o   (mid_beat)
  );

  // leap year, day of year and day number
  gdn_ordinal u_ordinal (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (mid_valid),
    .in_stall_o  (mid_stall),
    .in_mid_i    (mid_beat),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_beat_o  (out_beat_o)
  );

endmodule

`default_nettype wire
